// ----- src/set_assoc_lru_cache_defines.svh -----
`ifndef SET_ASSOC_LRU_CACHE_DEFINES_SVH
`define SET_ASSOC_LRU_CACHE_DEFINES_SVH

// Same-cycle implication, checked outside reset.
`define SAC_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked outside reset.
`define SAC_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- src/sac_pkg.sv -----
`timescale 1ns / 1ps

package sac_pkg;

    localparam int NUM_SETS    = 256;
    localparam int WAYS        = 4;
    localparam int OFFSET_BITS = 2;

    localparam int SET_BITS  = $clog2(NUM_SETS);
    localparam int TAG_BITS  = 32 - OFFSET_BITS - SET_BITS;
    localparam int WAY_BITS  = (WAYS > 1) ? $clog2(WAYS) : 1;
    localparam int RANK_BITS = WAY_BITS;

    localparam logic [SET_BITS-1:0] SET_MASK = SET_BITS'(NUM_SETS - 1);

    typedef struct packed {
        logic        action;
        logic [31:0] address;
        logic [31:0] write_data;
        logic [31:0] mem_word;
    } in_t;

    typedef struct packed {
        logic        hit;
        logic [31:0] read_data;
        logic        mem_write;
    } out_t;

    typedef logic [WAYS-1:0][TAG_BITS-1:0]  tag_row_t;
    typedef logic [WAYS-1:0][31:0]          data_row_t;
    typedef logic [WAYS-1:0][RANK_BITS-1:0] rank_row_t;

    typedef struct packed {
        logic [WAYS-1:0] valid;
        rank_row_t       ranks;
    } meta_t;

    typedef struct packed {
        logic load;
        logic commit;
    } cmd_t;

    function automatic meta_t meta_reset();
        meta_t m;
        m.valid = '0;
        for (int w = 0; w < WAYS; w++) begin
            m.ranks[w] = RANK_BITS'(w);
        end
        return m;
    endfunction

    localparam meta_t META_RESET = meta_reset();

    function automatic logic [SET_BITS-1:0] set_of(logic [31:0] addr);
        logic [31:0] word;
        word = addr >> OFFSET_BITS;
        return word[SET_BITS-1:0] & SET_MASK;
    endfunction

    function automatic logic [TAG_BITS-1:0] tag_of(logic [31:0] addr);
        logic [31:0] shifted;
        shifted = addr >> (OFFSET_BITS + SET_BITS);
        return shifted[TAG_BITS-1:0];
    endfunction

endpackage

// ----- src/sac_ctrl.sv -----
`timescale 1ns / 1ps

module sac_ctrl (
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          s_valid,
    output logic          s_ready,
    output logic          m_valid,
    input  logic          m_ready,
    output sac_pkg::cmd_t cmd
);

    localparam logic S_IDLE   = 1'b0;
    localparam logic S_LOOKUP = 1'b1;

    logic state_reg, state_next;
    logic m_valid_reg, m_valid_next;

    assign s_ready    = (state_reg == S_IDLE);
    assign cmd.load   = s_valid && s_ready;
    // commit only when the output slot is free or frees this cycle
    assign cmd.commit = (state_reg == S_LOOKUP) && (!m_valid_reg || m_ready);
    assign m_valid    = m_valid_reg;

    always_comb begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE: begin
                if (cmd.load) begin
                    state_next = S_LOOKUP;
                end
            end
            S_LOOKUP: begin
                if (cmd.commit) begin
                    state_next = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_comb begin
        if (cmd.commit) begin
            m_valid_next = 1'b1;
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end else begin
            m_valid_next = m_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= S_IDLE;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            m_valid_reg <= m_valid_next;
        end
    end

endmodule

// ----- src/sac_dp.sv -----
`timescale 1ns / 1ps

module sac_dp (
    input  logic          aclk,
    input  logic          aresetn,
    input  sac_pkg::cmd_t cmd,
    input  sac_pkg::in_t  s_payload,
    output sac_pkg::out_t m_payload
);

    sac_pkg::in_t      in_reg;
    sac_pkg::out_t     out_reg, out_next;

    sac_pkg::tag_row_t  tag_mem  [sac_pkg::NUM_SETS];
    sac_pkg::data_row_t data_mem [sac_pkg::NUM_SETS];
    sac_pkg::meta_t     meta_mem [sac_pkg::NUM_SETS];

    sac_pkg::tag_row_t  tag_rd_reg;
    sac_pkg::data_row_t data_rd_reg;
    sac_pkg::meta_t     meta_rd_reg;
    logic               touched_rd_reg;

    // one flag per set: an untouched set reads as its reset state
    logic [sac_pkg::NUM_SETS-1:0] touched_reg;

    logic [sac_pkg::SET_BITS-1:0] rd_set;
    logic [sac_pkg::SET_BITS-1:0] in_set;
    logic [sac_pkg::TAG_BITS-1:0] in_tag;

    sac_pkg::meta_t                meta, meta_next;
    sac_pkg::tag_row_t             tag_next;
    sac_pkg::data_row_t            data_next;
    logic                          hit_any;
    logic [sac_pkg::WAY_BITS-1:0]  hit_way, victim, way;
    logic [sac_pkg::RANK_BITS-1:0] old_rank;
    logic [31:0]                   cached;

    assign in_set = sac_pkg::set_of(in_reg.address);
    assign in_tag = sac_pkg::tag_of(in_reg.address);
    assign rd_set = cmd.load ? sac_pkg::set_of(s_payload.address) : in_set;

    always_comb begin
        meta    = touched_rd_reg ? meta_rd_reg : sac_pkg::META_RESET;
        hit_any = 1'b0;
        hit_way = '0;
        // scan downwards so the lowest matching way wins
        for (int w = sac_pkg::WAYS - 1; w >= 0; w--) begin
            if (meta.valid[w] && tag_rd_reg[w] == in_tag) begin
                hit_any = 1'b1;
                hit_way = sac_pkg::WAY_BITS'(w);
            end
        end
        victim = '0;
        for (int w = 1; w < sac_pkg::WAYS; w++) begin
            if (meta.ranks[w] > meta.ranks[victim]) begin
                victim = sac_pkg::WAY_BITS'(w);
            end
        end
        way      = hit_any ? hit_way : victim;
        cached   = data_rd_reg[way];
        old_rank = meta.ranks[way];

        meta_next = meta;
        meta_next.valid[way] = 1'b1;
        for (int w = 0; w < sac_pkg::WAYS; w++) begin
            if (meta.ranks[w] < old_rank) begin
                meta_next.ranks[w] = meta.ranks[w] + 1'b1;
            end
        end
        meta_next.ranks[way] = '0;

        tag_next      = tag_rd_reg;
        tag_next[way] = in_tag;

        data_next = data_rd_reg;
        if (in_reg.action) begin
            data_next[way] = in_reg.write_data;
        end else if (!hit_any) begin
            data_next[way] = in_reg.mem_word;
        end

        out_next.hit       = hit_any;
        out_next.mem_write = in_reg.action;
        if (in_reg.action) begin
            out_next.read_data = '0;
        end else if (hit_any) begin
            out_next.read_data = cached;
        end else begin
            out_next.read_data = in_reg.mem_word;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.load) begin
            in_reg <= s_payload;
        end
        if (cmd.commit) begin
            out_reg <= out_next;
        end
    end

    // set rows: read every cycle, write back the whole row on commit
    always_ff @(posedge aclk) begin
        if (cmd.commit) begin
            tag_mem[in_set]  <= tag_next;
            data_mem[in_set] <= data_next;
            meta_mem[in_set] <= meta_next;
        end
        tag_rd_reg  <= tag_mem[rd_set];
        data_rd_reg <= data_mem[rd_set];
        meta_rd_reg <= meta_mem[rd_set];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            touched_reg    <= '0;
            touched_rd_reg <= 1'b0;
        end else begin
            if (cmd.commit) begin
                touched_reg[in_set] <= 1'b1;
            end
            touched_rd_reg <= touched_reg[rd_set];
        end
    end

    assign m_payload = out_reg;

endmodule

// ----- src/set_assoc_lru_cache.sv -----
// Set-associative LRU cache, write-through and write-allocate, one word per line.
// Input channel s_valid/s_ready/s_payload carries one access word: action
// (0 read, 1 write), address, write_data and mem_word, the backing memory
// word used to fill the line on a read miss.
// Result channel m_valid/m_ready/m_payload returns one word per access: hit,
// read_data (cached word, fill word, or zero on a write) and mem_write, which
// asks for the write-through on every write.
// The result is registered: an accepted access is captured with its set's rows,
// and its result enters the output register when it commits.
// One access is in flight at a time: no new access is accepted until the last
// commits. The set's tag, data and LRU rows are read into registers and
// written back whole on commit.
// A finished result waits in the output register while the next access is
// accepted and looked up; that lookup holds until the result is taken.
// Reset clears the set flags at once, so every set reads as empty with way i
// at rank i; no clearing pass runs and the block is ready right after reset.
`timescale 1ns / 1ps
`include "set_assoc_lru_cache_defines.svh"

module set_assoc_lru_cache (
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          s_valid,
    output logic          s_ready,
    input  sac_pkg::in_t  s_payload,
    output logic          m_valid,
    input  logic          m_ready,
    output sac_pkg::out_t m_payload
);

    sac_pkg::cmd_t cmd;

    sac_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .cmd     (cmd)
    );

    sac_dp u_dp (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cmd       (cmd),
        .s_payload (s_payload),
        .m_payload (m_payload)
    );

    `SAC_ASSERT_NEXT(a_one_in_flight, s_valid && s_ready, !s_ready, "second word accepted during lookup")
    `SAC_ASSERT_NEXT(a_commit_shows, cmd.commit, m_valid, "committed result not presented")
    `SAC_ASSERT_NOW(a_write_zero, m_valid && m_payload.mem_write, m_payload.read_data == 32'd0, "write result carries data")
    `SAC_ASSERT_NOW(a_load_commit, cmd.load, !cmd.commit, "load and commit in the same cycle")

endmodule

// ----- bench/tb.sv -----
`timescale 1ns / 1ps

module tb;

    localparam logic ACT_READ  = 1'b0;
    localparam logic ACT_WRITE = 1'b1;
    localparam int   HOT_TAGS  = 6;
    localparam int   HOT_SETS  = 3;
    localparam int   PHASE_LEN = 376;
    localparam int   SHOW_MAX  = 40;

    typedef struct packed {
        sac_pkg::in_t  acc;
        logic          typed;
        sac_pkg::out_t res;
    } step_t;

    logic          aclk = 1'b0;
    logic          aresetn;
    logic          s_valid;
    logic          s_ready;
    sac_pkg::in_t  s_payload;
    logic          m_valid;
    logic          m_ready;
    sac_pkg::out_t m_payload;

    always #4 aclk = ~aclk;

    set_assoc_lru_cache dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_payload (s_payload),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_payload (m_payload)
    );

    // shadow copy of the cache contents
    logic [31:0] line_tag   [sac_pkg::NUM_SETS][sac_pkg::WAYS];
    logic [31:0] line_word  [sac_pkg::NUM_SETS][sac_pkg::WAYS];
    bit          line_valid [sac_pkg::NUM_SETS][sac_pkg::WAYS];
    int unsigned line_age   [sac_pkg::NUM_SETS][sac_pkg::WAYS];

    sac_pkg::out_t pending_results[$];
    step_t         directed_steps[$];
    int            errors;
    int            results_seen;
    int            send_gap;
    int            recv_gap;
    int            recv_hold;
    int            read_hits, read_misses, write_hits, write_misses;

    logic [sac_pkg::TAG_BITS-1:0] hot_tags [HOT_TAGS];
    logic [sac_pkg::SET_BITS-1:0] hot_sets [HOT_SETS];

    task automatic report_mismatch(input string what);
        if (errors < SHOW_MAX) begin
            $display("[%0t] mismatch: %s", $realtime, what);
        end
        errors++;
    endtask

    function automatic void clear_cache();
        for (int s = 0; s < sac_pkg::NUM_SETS; s++) begin
            for (int w = 0; w < sac_pkg::WAYS; w++) begin
                line_valid[s][w] = 1'b0;
                line_age[s][w]   = w;
            end
        end
    endfunction

    // look the access up, update tags, data and recency, return the result word
    function automatic sac_pkg::out_t cache_access(input sac_pkg::in_t a);
        logic [31:0]   word;
        int unsigned   set_idx;
        logic [31:0]   tag;
        int            way;
        int unsigned   old_age;
        bit            found;
        sac_pkg::out_t r;
        word    = a.address >> sac_pkg::OFFSET_BITS;
        set_idx = word & (sac_pkg::NUM_SETS - 1);
        tag     = word >> sac_pkg::SET_BITS;
        found   = 1'b0;
        way     = 0;
        for (int w = 0; w < sac_pkg::WAYS; w++) begin
            if (!found && line_valid[set_idx][w] && line_tag[set_idx][w] == tag) begin
                found = 1'b1;
                way   = w;
            end
        end
        if (!found) begin
            // victim is the oldest way; empty ways always hold the oldest ranks
            for (int w = 1; w < sac_pkg::WAYS; w++) begin
                if (line_age[set_idx][w] > line_age[set_idx][way]) begin
                    way = w;
                end
            end
            line_tag[set_idx][way]   = tag;
            line_valid[set_idx][way] = 1'b1;
        end
        r.hit       = found;
        r.mem_write = a.action;
        r.read_data = '0;
        if (a.action == ACT_WRITE) begin
            line_word[set_idx][way] = a.write_data;
            if (found) write_hits++; else write_misses++;
        end else begin
            if (!found) line_word[set_idx][way] = a.mem_word;
            r.read_data = line_word[set_idx][way];
            if (found) read_hits++; else read_misses++;
        end
        old_age = line_age[set_idx][way];
        for (int w = 0; w < sac_pkg::WAYS; w++) begin
            if (line_age[set_idx][w] < old_age) line_age[set_idx][w]++;
        end
        line_age[set_idx][way] = 0;
        return r;
    endfunction

    function automatic logic [31:0] addr_of(input int unsigned t, input int unsigned s);
        return (32'(t) << (sac_pkg::SET_BITS + sac_pkg::OFFSET_BITS))
             | ((32'(s) & 32'(sac_pkg::NUM_SETS - 1)) << sac_pkg::OFFSET_BITS);
    endfunction

    function automatic void add_step(input logic act, input logic [31:0] addr,
                                     input logic [31:0] wd, input logic [31:0] mw,
                                     input logic typed, input logic h,
                                     input logic [31:0] rd);
        step_t st;
        st.acc.action     = act;
        st.acc.address    = addr;
        st.acc.write_data = wd;
        st.acc.mem_word   = mw;
        st.typed          = typed;
        st.res.hit        = h;
        st.res.read_data  = rd;
        st.res.mem_write  = act;
        directed_steps.push_back(st);
    endfunction

    function automatic void pick_hot_lines(input int phase);
        for (int i = 0; i < HOT_TAGS; i++) hot_tags[i] = sac_pkg::TAG_BITS'($urandom());
        for (int i = 0; i < HOT_SETS; i++) hot_sets[i] = sac_pkg::SET_BITS'($urandom());
        hot_tags[$urandom_range(HOT_TAGS - 1)] = (phase == 1) ? '1 : '0;
        hot_sets[$urandom_range(HOT_SETS - 1)] = (phase == 2) ? '1 : '0;
    endfunction

    // mostly a few busy sets with more tags than ways, so hits and evictions mix
    function automatic sac_pkg::in_t random_access();
        sac_pkg::in_t a;
        a.action = ($urandom_range(1) == 1) ? ACT_WRITE : ACT_READ;
        if ($urandom_range(99) < 85) begin
            a.address = addr_of(32'(hot_tags[$urandom_range(HOT_TAGS - 1)]),
                                32'(hot_sets[$urandom_range(HOT_SETS - 1)]))
                      | 32'($urandom_range((1 << sac_pkg::OFFSET_BITS) - 1));
        end else begin
            a.address = $urandom();
        end
        a.write_data = $urandom();
        a.mem_word   = $urandom();
        return a;
    endfunction

    task automatic offer(input sac_pkg::in_t a, input logic typed,
                         input sac_pkg::out_t typed_res);
        sac_pkg::out_t want;
        @(negedge aclk);
        while ($urandom_range(99) < send_gap) begin
            s_valid <= 1'b0;
            @(negedge aclk);
        end
        s_valid   <= 1'b1;
        s_payload <= a;
        do @(posedge aclk); while (!s_ready);
        want = cache_access(a);
        pending_results.push_back(typed ? typed_res : want);
    endtask

    // hold the input until every outstanding result is back
    task automatic drain();
        @(negedge aclk);
        s_valid <= 1'b0;
        while (pending_results.size() != 0) @(posedge aclk);
    endtask

    always @(posedge aclk) begin : check_results
        sac_pkg::out_t want;
        if (aresetn && m_valid && m_ready) begin
            if (pending_results.size() == 0) begin
                report_mismatch($sformatf("result %0d arrived with none outstanding",
                                          results_seen));
            end else begin
                want = pending_results.pop_front();
                if (m_payload.hit !== want.hit)
                    report_mismatch($sformatf("result %0d hit %b, expected %b",
                                              results_seen, m_payload.hit, want.hit));
                if (m_payload.read_data !== want.read_data)
                    report_mismatch($sformatf("result %0d read_data %h, expected %h",
                                              results_seen, m_payload.read_data,
                                              want.read_data));
                if (m_payload.mem_write !== want.mem_write)
                    report_mismatch($sformatf("result %0d mem_write %b, expected %b",
                                              results_seen, m_payload.mem_write,
                                              want.mem_write));
            end
            results_seen++;
        end
    end

    initial begin : result_sink
        m_ready = 1'b0;
        @(posedge aresetn);
        forever begin
            @(negedge aclk);
            if (recv_hold > 0) begin
                m_ready <= 1'b0;
                recv_hold--;
            end else begin
                m_ready <= ($urandom_range(99) >= recv_gap);
            end
        end
    end

    initial begin : watchdog
        #2000000;
        $display("TEST FAILED");
        $finish;
    end

    initial begin : stimulus
        int            spins;
        sac_pkg::out_t none;
        aresetn      = 1'b0;
        s_valid      = 1'b0;
        s_payload    = '0;
        errors       = 0;
        results_seen = 0;
        recv_hold    = 0;
        send_gap     = 38;
        recv_gap     = 58;
        read_hits    = 0;
        read_misses  = 0;
        write_hits   = 0;
        write_misses = 0;
        none         = '0;
        clear_cache();

        // first access after reset misses; offset bits do not change the line
        add_step(ACT_READ,  32'h0, 32'h0, 32'hDEAD_BEEF, 1'b1, 1'b0, 32'hDEAD_BEEF);
        add_step(ACT_READ,  32'h3, 32'h0, 32'h0,         1'b1, 1'b1, 32'hDEAD_BEEF);
        add_step(ACT_WRITE, 32'h0, 32'h1234_5678, 32'h0, 1'b1, 1'b1, 32'h0);
        add_step(ACT_READ,  32'h0, 32'h0, 32'h5555_5555, 1'b1, 1'b1, 32'h1234_5678);
        // all-ones tag is an ordinary tag once the line is marked valid
        add_step(ACT_WRITE, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF,
                 1'b1, 1'b0, 32'h0);
        add_step(ACT_READ,  32'hFFFF_FFFF, 32'h0, 32'h0, 1'b1, 1'b1, 32'hFFFF_FFFF);
        // fill set 0, then evict in recency order
        add_step(ACT_READ,  addr_of(1, 0), 32'h0, 32'hA1A1_A1A1, 1'b0, 1'b0, 32'h0);
        add_step(ACT_READ,  addr_of(2, 0), 32'h0, 32'hA2A2_A2A2, 1'b0, 1'b0, 32'h0);
        add_step(ACT_READ,  addr_of(3, 0), 32'h0, 32'hA3A3_A3A3, 1'b0, 1'b0, 32'h0);
        add_step(ACT_READ,  addr_of(4, 0), 32'h0, 32'hA4A4_A4A4, 1'b0, 1'b0, 32'h0);
        add_step(ACT_READ,  addr_of(0, 0), 32'h0, 32'hA0A0_A0A0, 1'b0, 1'b0, 32'h0);
        // a write hit promotes its way too
        add_step(ACT_WRITE, addr_of(2, 0), 32'hB2B2_B2B2, 32'h0, 1'b0, 1'b0, 32'h0);
        add_step(ACT_READ,  addr_of(5, 0), 32'h0, 32'hA5A5_A5A5, 1'b0, 1'b0, 32'h0);
        add_step(ACT_READ,  addr_of(2, 0), 32'h0, 32'h0, 1'b0, 1'b0, 32'h0);
        add_step(ACT_READ,  addr_of(3, 0), 32'h0, 32'hC3C3_C3C3, 1'b0, 1'b0, 32'h0);
        // write miss allocates
        add_step(ACT_WRITE, addr_of(0, 7), 32'hCAFE_F00D, 32'h0, 1'b1, 1'b0, 32'h0);
        add_step(ACT_READ,  addr_of(0, 7), 32'h0, 32'h0, 1'b1, 1'b1, 32'hCAFE_F00D);
        add_step(ACT_WRITE, addr_of(6, 0), 32'h6666_6666, 32'h0, 1'b0, 1'b0, 32'h0);
        add_step(ACT_READ,  addr_of(6, 0), 32'h0, 32'h0, 1'b0, 1'b0, 32'h0);
        add_step(ACT_READ,  32'h0000_0004, 32'h0, 32'h0, 1'b1, 1'b0, 32'h0);
        add_step(ACT_WRITE, 32'h7FFF_FFFC, 32'h8000_0000, 32'h0, 1'b1, 1'b0, 32'h0);
        add_step(ACT_READ,  32'h7FFF_FFFC, 32'h0, 32'hFFFF_FFFF, 1'b0, 1'b0, 32'h0);

        repeat (3) @(negedge aclk);
        aresetn = 1'b1;

        foreach (directed_steps[i])
            offer(directed_steps[i].acc, directed_steps[i].typed, directed_steps[i].res);
        drain();

        for (int phase = 0; phase < 3; phase++) begin
            send_gap = (phase == 0) ? 38 : (phase == 1) ? 58 : 0;
            recv_gap = (phase == 0) ? 58 : (phase == 1) ? 38 : 0;
            pick_hot_lines(phase);
            // stall the result side long enough to back the block up
            if (phase == 0) recv_hold = 80;
            for (int n = 0; n < PHASE_LEN; n++) offer(random_access(), 1'b0, none);
            drain();
        end

        @(negedge aclk);
        s_valid <= 1'b0;
        spins = 0;
        while (pending_results.size() != 0 && spins < 20000) begin
            @(posedge aclk);
            spins++;
        end
        repeat (8) @(posedge aclk);
        if (pending_results.size() != 0)
            report_mismatch($sformatf("%0d results never arrived", pending_results.size()));

        $display("covered %0d accesses: %0d read hits, %0d read misses,",
                 read_hits + read_misses + write_hits + write_misses,
                 read_hits, read_misses);
        $display("%0d write hits, %0d write misses, a long result stall, full drains",
                 write_hits, write_misses);
        $display("and three idle mixes; %0d mismatches", errors);
        if (errors == 0) begin
            $display("TEST PASSED");
        end else begin
            $display("TEST FAILED");
        end
        $finish;
    end

endmodule
